### rtl/rsn_pkg.sv
// Shared types, step schedule and helpers for the ray/sphere nearest-hit block.
package rsn_pkg;

  localparam int SPHERES   = 8;
  localparam int FRAC_BITS = 16;
  localparam int DIR_FRAC  = 30;
  localparam int IDX_W     = 3;
  localparam int POS_W     = 32;
  localparam int RAD_W     = 31;
  localparam int RSQ_W     = 2 * RAD_W;
  localparam int DIST_W    = 31;
  localparam int CNT_W     = 4;
  localparam int PROD_W    = 64;
  localparam int DOT_W     = PROD_W + 3;
  localparam int LL_W      = PROD_W + 2;
  localparam int TCA_W     = DOT_W - 1 - DIR_FRAC;
  localparam int TSQ_W     = 2 * TCA_W;
  localparam int MA_W      = TCA_W;
  localparam int MB_W      = 32;
  localparam int MP_W      = MA_W + MB_W;
  localparam int T_W       = TCA_W + 1;
  localparam int THC_W     = RAD_W;

  // per-ray step schedule of every cell
  localparam int ST_SUB    = 0;
  localparam int ST_MX     = 1;
  localparam int ST_MY     = 2;
  localparam int ST_MZ     = 3;
  localparam int ST_SX     = 4;
  localparam int ST_SY     = 5;
  localparam int ST_SZ     = 6;
  localparam int ST_TCA    = 7;
  localparam int ST_TSQ0   = 8;
  localparam int ST_TSQ1   = 9;
  localparam int ST_TSQ2   = 10;
  localparam int ST_D2     = 11;
  localparam int ST_RAD    = 12;
  localparam int ST_SQ     = 13;
  localparam int SQ_ITERS  = RSQ_W / 2;
  localparam int ST_T      = ST_SQ + SQ_ITERS;
  localparam int ST_LAST   = ST_T + 1 + SPHERES;
  localparam int STEP_W    = $clog2(ST_LAST + 1);

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    logic  run;
    step_t step;
  } ctl_t;

  typedef struct packed {
    logic                    en;
    logic [IDX_W-1:0]        slot;
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic signed [POS_W-1:0] cz;
    logic [RAD_W-1:0]        radius;
  } wr_t;

  typedef struct packed {
    logic signed [POS_W-1:0] ox;
    logic signed [POS_W-1:0] oy;
    logic signed [POS_W-1:0] oz;
    logic [POS_W-1:0]        dmx;
    logic [POS_W-1:0]        dmy;
    logic [POS_W-1:0]        dmz;
    logic                    dsx;
    logic                    dsy;
    logic                    dsz;
  } ray_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [T_W-1:0]   t;
  } best_t;

  // magnitude of a 33-bit signed difference; fits in 32 bits
  function automatic logic [POS_W-1:0] mag33(input logic signed [POS_W:0] v);
    logic [POS_W:0] m;
    m = v[POS_W] ? (~v + 1'b1) : v;
    return m[POS_W-1:0];
  endfunction

endpackage

### rtl/rsn_cell.sv
// One sphere cell: holds a slot, runs the geometric test, merges into the passing best hit.
module rsn_cell (
  input  logic                    clk,
  input  logic [rsn_pkg::IDX_W-1:0] idx,
  input  logic                    en,
  input  rsn_pkg::ctl_t           ctl,
  input  rsn_pkg::wr_t            wr,
  input  rsn_pkg::ray_t           ray,
  input  rsn_pkg::best_t          best_in,
  output rsn_pkg::best_t          best_out
);
  import rsn_pkg::*;

  logic signed [POS_W-1:0] cx, cy, cz;
  logic [RSQ_W-1:0]        rsq;

  logic [POS_W-1:0] lmx, lmy, lmz;
  logic             lsx, lsy, lsz;
  logic [MA_W-1:0]  mul_a;
  logic [MB_W-1:0]  mul_b;
  logic [MP_W-1:0]  prod;
  logic [PROD_W-1:0] p64;
  logic signed [DOT_W-1:0] dot, p_pos, p_neg;
  logic [LL_W-1:0]  ll;
  logic [TCA_W-1:0] tca;
  logic [TSQ_W-1:0] tsq;
  logic [LL_W-1:0]  d2;
  logic             rej;
  logic [RSQ_W-1:0] rad, res, sbit, trial;
  logic [T_W-1:0]   t;
  logic             cand;
  logic signed [POS_W:0] lx_w, ly_w, lz_w;
  logic             psign;

  always_ff @(posedge clk) begin
    if (wr.en && wr.slot == idx) begin
      cx  <= wr.cx;
      cy  <= wr.cy;
      cz  <= wr.cz;
      rsq <= RSQ_W'(wr.radius) * RSQ_W'(wr.radius);
    end
  end

  assign lx_w = {cx[POS_W-1], cx} - {ray.ox[POS_W-1], ray.ox};
  assign ly_w = {cy[POS_W-1], cy} - {ray.oy[POS_W-1], ray.oy};
  assign lz_w = {cz[POS_W-1], cz} - {ray.oz[POS_W-1], ray.oz};

  // one shared multiplier, operands picked by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.step)
      STEP_W'(ST_MX):   begin mul_a = MA_W'(lmx); mul_b = ray.dmx; end
      STEP_W'(ST_MY):   begin mul_a = MA_W'(lmy); mul_b = ray.dmy; end
      STEP_W'(ST_MZ):   begin mul_a = MA_W'(lmz); mul_b = ray.dmz; end
      STEP_W'(ST_SX):   begin mul_a = MA_W'(lmx); mul_b = lmx; end
      STEP_W'(ST_SY):   begin mul_a = MA_W'(lmy); mul_b = lmy; end
      STEP_W'(ST_SZ):   begin mul_a = MA_W'(lmz); mul_b = lmz; end
      STEP_W'(ST_TSQ0): begin mul_a = tca; mul_b = tca[MB_W-1:0]; end
      STEP_W'(ST_TSQ1): begin mul_a = tca; mul_b = MB_W'(tca[TCA_W-1:MB_W]); end
      default:          begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // sign of the product in flight (set for the step that consumes it)
  always_comb begin
    case (ctl.step)
      STEP_W'(ST_MY): psign = lsx ^ ray.dsx;
      STEP_W'(ST_MZ): psign = lsy ^ ray.dsy;
      STEP_W'(ST_SX): psign = lsz ^ ray.dsz;
      default:        psign = 1'b0;
    endcase
  end

  assign p64   = prod[PROD_W-1:0];
  assign p_pos = DOT_W'(p64);
  assign p_neg = -p_pos;
  assign trial = res + sbit;

  always_ff @(posedge clk) begin
    prod <= MP_W'(mul_a) * MP_W'(mul_b);
    if (ctl.run) begin
      case (ctl.step)
        STEP_W'(ST_SUB): begin
          lmx  <= mag33(lx_w);
          lmy  <= mag33(ly_w);
          lmz  <= mag33(lz_w);
          lsx  <= lx_w[POS_W];
          lsy  <= ly_w[POS_W];
          lsz  <= lz_w[POS_W];
          rej  <= 1'b0;
          cand <= 1'b0;
        end
        STEP_W'(ST_MY): dot <= psign ? p_neg : p_pos;
        STEP_W'(ST_MZ): dot <= dot + (psign ? p_neg : p_pos);
        STEP_W'(ST_SX): dot <= dot + (psign ? p_neg : p_pos);
        STEP_W'(ST_SY): ll  <= LL_W'(p64);
        STEP_W'(ST_SZ): ll  <= ll + LL_W'(p64);
        STEP_W'(ST_TCA): begin
          ll  <= ll + LL_W'(p64);
          tca <= dot[DOT_W-2:DIR_FRAC];
          rej <= dot[DOT_W-1];
        end
        STEP_W'(ST_TSQ1): tsq <= TSQ_W'(prod);
        STEP_W'(ST_TSQ2): tsq <= tsq + {prod[TSQ_W-MB_W-1:0], {MB_W{1'b0}}};
        STEP_W'(ST_D2): begin
          d2 <= (TSQ_W'(ll) >= tsq) ? (ll - tsq[LL_W-1:0]) : '0;
        end
        STEP_W'(ST_RAD): begin
          if (LL_W'(rsq) < d2) rej <= 1'b1;
          rad  <= rsq - d2[RSQ_W-1:0];
          res  <= '0;
          sbit <= RSQ_W'(1) << (RSQ_W - 2);
        end
        STEP_W'(ST_T): begin
          if (tca >= TCA_W'(res[THC_W-1:0]))
            t <= T_W'(tca) - T_W'(res[THC_W-1:0]);
          else
            t <= T_W'(tca) + T_W'(res[THC_W-1:0]);
          cand <= en & ~rej;
        end
        default: begin
          // floor square root, one result bit per step
          if (ctl.step >= STEP_W'(ST_SQ) && ctl.step < STEP_W'(ST_T)) begin
            if (rad >= trial) begin
              rad <= rad - trial;
              res <= (res >> 1) + sbit;
            end else begin
              res <= res >> 1;
            end
            sbit <= sbit >> 2;
          end
        end
      endcase
    end
  end

  // lower slots come in from the left, so a tie keeps the incoming hit
  always_ff @(posedge clk) begin
    if (cand && (!best_in.found || t < best_in.t)) begin
      best_out.found <= 1'b1;
      best_out.idx   <= idx;
      best_out.t     <= t;
    end else begin
      best_out <= best_in;
    end
  end

endmodule

### rtl/ray_sphere_nearest_hit.sv
// Top level: command port, sphere_count register, step sequencer and the row of cells.
// A sphere write (mode 0) is taken while busy is low and leaves busy low; no result.
// A ray (mode 1) holds busy high from step 0 through ST_LAST: first the per-cell test
// (shared multiplier steps, a 31-step square root, the t step), then the best hit
// ripples down the row, then the done step; no new ray is taken until busy drops.
// rst (synchronous) clears busy and sphere_count; sphere slots stay unset; no stall.
module ray_sphere_nearest_hit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             sphere_count_we,
  input  logic [rsn_pkg::CNT_W-1:0]        sphere_count,
  input  logic                             mode,
  input  logic [rsn_pkg::IDX_W-1:0]        slot,
  input  logic signed [rsn_pkg::POS_W-1:0] center_x,
  input  logic signed [rsn_pkg::POS_W-1:0] center_y,
  input  logic signed [rsn_pkg::POS_W-1:0] center_z,
  input  logic [rsn_pkg::RAD_W-1:0]        radius,
  input  logic signed [rsn_pkg::POS_W-1:0] origin_x,
  input  logic signed [rsn_pkg::POS_W-1:0] origin_y,
  input  logic signed [rsn_pkg::POS_W-1:0] origin_z,
  input  logic signed [rsn_pkg::POS_W-1:0] dir_x,
  input  logic signed [rsn_pkg::POS_W-1:0] dir_y,
  input  logic signed [rsn_pkg::POS_W-1:0] dir_z,
  output logic                             done,
  output logic                             hit,
  output logic [rsn_pkg::IDX_W-1:0]        hit_index,
  output logic [rsn_pkg::DIST_W-1:0]       distance
);
  import rsn_pkg::*;

  logic [CNT_W-1:0] count;
  step_t            step;
  ctl_t             ctl;
  wr_t              wr;
  ray_t             ray;
  logic             take;
  best_t            chain [SPHERES+1];
  best_t            last;

  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b0;
      step  <= '0;
    end else begin
      if (sphere_count_we) count <= sphere_count;
      if (take && mode) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(ST_LAST)) busy <= 1'b0;
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && mode) begin
      ray.ox  <= origin_x;
      ray.oy  <= origin_y;
      ray.oz  <= origin_z;
      ray.dmx <= mag33({dir_x[POS_W-1], dir_x});
      ray.dmy <= mag33({dir_y[POS_W-1], dir_y});
      ray.dmz <= mag33({dir_z[POS_W-1], dir_z});
      ray.dsx <= dir_x[POS_W-1];
      ray.dsy <= dir_y[POS_W-1];
      ray.dsz <= dir_z[POS_W-1];
    end
  end

  assign ctl.run = busy;
  assign ctl.step = step;

  assign wr.en     = take && !mode;
  assign wr.slot   = slot;
  assign wr.cx     = center_x;
  assign wr.cy     = center_y;
  assign wr.cz     = center_z;
  assign wr.radius = radius;

  assign chain[0] = '0;

  for (genvar i = 0; i < SPHERES; i++) begin : g_cell
    rsn_cell u_cell (
      .clk      (clk),
      .idx      (IDX_W'(i)),
      .en       (CNT_W'(i) < count),
      .ctl      (ctl),
      .wr       (wr),
      .ray      (ray),
      .best_in  (chain[i]),
      .best_out (chain[i+1])
    );
  end

  assign last      = chain[SPHERES];
  assign done      = busy && step == STEP_W'(ST_LAST);
  assign hit       = last.found;
  assign hit_index = last.found ? last.idx : '0;
  always_comb begin
    if (!last.found)
      distance = '0;
    else if (last.t > T_W'(DIST_MAX))
      distance = DIST_MAX;
    else
      distance = last.t[DIST_W-1:0];
  end

endmodule

### sim/rsn_checker.sv
// Checker: tracks sphere slots and sphere_count, predicts each ray result and compares.
module rsn_checker
  import rsn_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic                    sphere_count_we,
  input  logic [CNT_W-1:0]        sphere_count,
  input  logic                    mode,
  input  logic [IDX_W-1:0]        slot,
  input  logic signed [POS_W-1:0] center_x,
  input  logic signed [POS_W-1:0] center_y,
  input  logic signed [POS_W-1:0] center_z,
  input  logic [RAD_W-1:0]        radius,
  input  logic signed [POS_W-1:0] origin_x,
  input  logic signed [POS_W-1:0] origin_y,
  input  logic signed [POS_W-1:0] origin_z,
  input  logic signed [POS_W-1:0] dir_x,
  input  logic signed [POS_W-1:0] dir_y,
  input  logic signed [POS_W-1:0] dir_z,
  input  logic                    done,
  input  logic                    hit,
  input  logic [IDX_W-1:0]        hit_index,
  input  logic [DIST_W-1:0]       distance,
  output int                      errors,
  output int                      pending
);

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] dist_sat;
  } nearest_t;

  logic signed [POS_W-1:0] bank_cx [SPHERES];
  logic signed [POS_W-1:0] bank_cy [SPHERES];
  logic signed [POS_W-1:0] bank_cz [SPHERES];
  logic [RSQ_W-1:0]        bank_rsq [SPHERES];
  logic [CNT_W-1:0]        count_q;
  nearest_t                hits_q[$];

  initial begin
    errors  = 0;
    pending = 0;
    count_q = '0;
  end

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic nearest_t trace_ray(
    input logic signed [POS_W-1:0] ox, oy, oz, dx, dy, dz);
    logic signed [127:0] lx, ly, lz, ex, ey, ez;
    logic signed [127:0] dot, tca, ll, tsq, d2, rsq, thc, t, best;
    int n;
    nearest_t r;
    r = '0;
    best = 0;
    n = (count_q > SPHERES) ? SPHERES : count_q;
    ex = dx;
    ey = dy;
    ez = dz;
    for (int i = 0; i < n; i++) begin
      lx = bank_cx[i];
      ly = bank_cy[i];
      lz = bank_cz[i];
      lx = lx - ox;
      ly = ly - oy;
      lz = lz - oz;
      dot = lx * ex + ly * ey + lz * ez;
      if (dot < 0) continue;
      tca = dot >>> DIR_FRAC;
      ll  = lx * lx + ly * ly + lz * lz;
      tsq = tca * tca;
      d2  = (ll >= tsq) ? ll - tsq : 0;
      rsq = {66'd0, bank_rsq[i]};
      if (d2 > rsq) continue;
      thc = floor_sqrt(64'(rsq - d2));
      t   = (tca >= thc) ? tca - thc : tca + thc;
      if (!r.hit || t < best) begin
        r.hit = 1'b1;
        r.idx = IDX_W'(i);
        best  = t;
      end
    end
    if (r.hit) r.dist_sat = (best > DIST_MAX) ? DIST_MAX : DIST_W'(best);
    return r;
  endfunction

  always @(posedge clk) begin
    nearest_t want;
    if (rst) begin
      count_q = '0;
    end else begin
      if (sphere_count_we) count_q = sphere_count;
      if (start && !busy) begin
        if (mode == 1'b0) begin
          // slot is 3 bits, so every write lands in the bank
          bank_cx[slot]  = center_x;
          bank_cy[slot]  = center_y;
          bank_cz[slot]  = center_z;
          bank_rsq[slot] = radius * radius;
        end else begin
          hits_q = {hits_q, trace_ray(origin_x, origin_y, origin_z, dir_x, dir_y, dir_z)};
        end
      end
      if (done) begin
        if (hits_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result beat: hit=%0d index=%0d distance=%h",
                     hit, hit_index, distance);
        end else begin
          want = hits_q.pop_front();
          if (hit !== want.hit || hit_index !== want.idx || distance !== want.dist_sat) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected hit=%0d index=%0d distance=%h, got %0d %0d %h",
                       want.hit, want.idx, want.dist_sat, hit, hit_index, distance);
          end
        end
      end
    end
    pending = hits_q.size();
  end

endmodule

### sim/testbench.sv
// Testbench top: drives sphere writes, rays and sphere_count settings, gives the verdict.
module testbench;
  import rsn_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 64;
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TRACE = 1'b1;
  localparam int UNIT = 65536;
  localparam int DIR_ONE = 1 << DIR_FRAC;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic                    sphere_count_we;
  logic [CNT_W-1:0]        sphere_count;
  logic                    mode;
  logic [IDX_W-1:0]        slot;
  logic signed [POS_W-1:0] center_x, center_y, center_z;
  logic [RAD_W-1:0]        radius;
  logic signed [POS_W-1:0] origin_x, origin_y, origin_z;
  logic signed [POS_W-1:0] dir_x, dir_y, dir_z;
  logic                    done;
  logic                    hit;
  logic [IDX_W-1:0]        hit_index;
  logic [DIST_W-1:0]       distance;
  int                      errors;
  int                      pending;
  int                      rays_sent;
  int                      rays_back;
  int                      cycles;
  bit                      quiet;
  real                     aim_x [SPHERES];
  real                     aim_y [SPHERES];
  real                     aim_z [SPHERES];

  ray_sphere_nearest_hit i_dut (.*);

  rsn_checker i_checker (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (done) rays_back++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // hold start until the beat is taken; busy only moves on rising edges
  task automatic take_beat();
    start <= 1'b1;
    do @(negedge clk); while (busy);
    @(posedge clk);
    if (!quiet && $urandom_range(99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic write_sphere(input int s, input int cx, input int cy, input int cz,
                              input int r);
    logic [IDX_W-1:0] s_idx;
    s_idx    = IDX_W'(s);
    mode     <= MODE_WRITE;
    slot     <= s_idx;
    center_x <= cx;
    center_y <= cy;
    center_z <= cz;
    radius   <= RAD_W'(r);
    origin_x <= $urandom;
    dir_x    <= $urandom;
    aim_x[s_idx] = real'(cx);
    aim_y[s_idx] = real'(cy);
    aim_z[s_idx] = real'(cz);
    take_beat();
  endtask

  task automatic trace(input int ox, input int oy, input int oz,
                       input int dx, input int dy, input int dz);
    mode     <= MODE_TRACE;
    slot     <= IDX_W'($urandom);
    center_x <= $urandom;
    radius   <= RAD_W'($urandom);
    origin_x <= ox;
    origin_y <= oy;
    origin_z <= oz;
    dir_x    <= dx;
    dir_y    <= dy;
    dir_z    <= dz;
    rays_sent++;
    take_beat();
  endtask

  task automatic drain();
    start <= 1'b0;
    while (rays_back != rays_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(input int v);
    sphere_count_we <= 1'b1;
    sphere_count    <= CNT_W'(v);
    @(posedge clk);
    sphere_count_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int near_coord();
    return $urandom_range(0, 200 * UNIT) - 100 * UNIT;
  endfunction

  function automatic int any_dir();
    return $urandom_range(0, 2 * DIR_ONE) - DIR_ONE;
  endfunction

  // ray from a nearby origin toward a jittered sphere center (now and then away from it), unit length
  task automatic aimed_ray();
    real ox, oy, oz, vx, vy, vz, len;
    int  s;
    s  = $urandom_range(0, SPHERES - 1);
    ox = real'(near_coord());
    oy = real'(near_coord());
    oz = real'(near_coord());
    vx = aim_x[s] + real'($urandom_range(0, 10 * UNIT)) - 5.0 * UNIT - ox;
    vy = aim_y[s] + real'($urandom_range(0, 10 * UNIT)) - 5.0 * UNIT - oy;
    vz = aim_z[s] + real'($urandom_range(0, 10 * UNIT)) - 5.0 * UNIT - oz;
    len = $sqrt(vx * vx + vy * vy + vz * vz);
    if (len < 1.0) begin
      vx = 1.0;
      len = 1.0;
    end
    if ($urandom_range(9) == 0) len = -len;  // pointing away
    trace($rtoi(ox), $rtoi(oy), $rtoi(oz), $rtoi(vx / len * DIR_ONE),
          $rtoi(vy / len * DIR_ONE), $rtoi(vz / len * DIR_ONE));
  endtask

  task automatic random_items(input int n);
    int pick;
    for (int k = 0; k < n; k++) begin
      quiet = (k >= n / 3) && (k < n / 2);
      pick = $urandom_range(99);
      if (pick < 10)
        write_sphere($urandom_range(0, SPHERES - 1), near_coord(), near_coord(),
                     near_coord(), $urandom_range(UNIT / 4, 30 * UNIT));
      else if (pick < 13)
        write_sphere($urandom, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 80)
        aimed_ray();
      else if (pick < 90)
        trace($urandom, $urandom, $urandom, any_dir(), any_dir(), any_dir());
      else
        trace(near_coord(), near_coord(), near_coord(), any_dir(), any_dir(), any_dir());
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    sphere_count_we = 1'b0;
    sphere_count = '0;
    mode = MODE_WRITE;
    slot = '0;
    center_x = '0;
    center_y = '0;
    center_z = '0;
    radius = '0;
    origin_x = '0;
    origin_y = '0;
    origin_z = '0;
    dir_x = '0;
    dir_y = '0;
    dir_z = '0;
    rays_sent = 0;
    rays_back = 0;
    cycles = 0;
    quiet = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every slot written before any ray; extreme centers and radii included
    write_sphere(0, 10 * UNIT, 0, 0, 2 * UNIT);
    write_sphere(1, 32'h7FFF_FFFF, 0, 0, 31'h7FFF_FFFF);
    write_sphere(2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    write_sphere(3, 0, 0, 0, 5 * UNIT);
    write_sphere(4, 0, 10 * UNIT, 0, UNIT);
    write_sphere(5, 0, 0, -10 * UNIT, 3 * UNIT);
    write_sphere(6, 10 * UNIT, 0, 0, 2 * UNIT);  // same as slot 0: tie
    write_sphere(7, -20 * UNIT, -20 * UNIT, 0, 4 * UNIT);
    drain();
    set_count(SPHERES);
    trace(-50 * UNIT, 0, 0, DIR_ONE, 0, 0);
    trace(50 * UNIT, 0, 0, -DIR_ONE, 0, 0);
    trace(0, -50 * UNIT, 0, 0, DIR_ONE, 0);
    trace(0, 50 * UNIT, 0, 0, -DIR_ONE, 0);
    trace(0, 0, -50 * UNIT, 0, 0, DIR_ONE);
    trace(0, 0, 50 * UNIT, 0, 0, -DIR_ONE);
    trace(0, 0, 0, 0, 0, DIR_ONE);  // origin inside a sphere
    trace(32'h8000_0000, 0, 0, DIR_ONE, 0, 0);  // far hit, distance just below the saturation value
    trace(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -DIR_ONE, -DIR_ONE, -DIR_ONE);
    trace(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, DIR_ONE, DIR_ONE, DIR_ONE);
    trace(32'h8000_0000, 32'h7FFF_FFFF, 0, -DIR_ONE, DIR_ONE, -DIR_ONE);
    trace(0, 0, 0, 0, 0, 0);
    drain();

    set_count(15);
    random_items(150);
    drain();
    set_count(0);
    random_items(60);
    drain();
    set_count(1);
    random_items(100);
    drain();
    set_count(SPHERES);
    random_items(250);
    drain();
    set_count($urandom_range(2, 7));
    random_items(140);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
